/* src/ilg_pkg.sv */
// shared constants, types and codes for the iou loss gradient block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ilg_pkg;

  localparam int DIST_FRAC_BITS = 6;
  localparam int GRAD_FRAC_BITS = 24;
  localparam int FACT_FRAC      = 24;
  localparam int WEIGHT_FRAC    = 24;

  localparam int DIST_W   = 16;
  localparam int EXT_W    = 18;
  localparam int AREA_W   = 36;
  localparam int UNION_W  = 38;
  localparam int GRAD_W   = 32;
  localparam int WEIGHT_W = 32;
  localparam int MINI_W   = 20;
  localparam int MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_IOU    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L1     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd2;

  localparam logic REG_LOSS_WEIGHT = 1'b0;
  localparam logic REG_MIN_INTER   = 1'b1;

  // one classified pixel as handed from the front to the back
  typedef struct packed {
    logic signed [UNION_W-1:0] uni_area;
    logic signed [AREA_W-1:0]  inter;
    logic signed [EXT_W-1:0]   ext_w;
    logic signed [EXT_W-1:0]   ext_h;
    logic signed [EXT_W-1:0]   ext_wi;
    logic signed [EXT_W-1:0]   ext_hi;
    logic [3:0]                lt;
    logic [3:0]                gt;
    logic [MODE_W-1:0]         mode;
  } item_t;

endpackage

`default_nettype wire

/* src/ilg_div.sv */
// pipelined restoring divider, one quotient bit per stage, lanes share a divisor
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module ilg_div #(
  parameter int DW    = 48,
  parameter int VW    = 38,
  parameter int LANES = 4
) (
  input  logic          clk_i,
  input  logic [DW-1:0] num_i [LANES],
  input  logic [VW-1:0] den_i,
  output logic [DW-1:0] quo_o [LANES]
);

  logic [VW-1:0] den_in [DW];
  logic [VW-1:0] rem_in [DW][LANES];
  logic [DW-1:0] dq_in  [DW][LANES];
  logic [VW-1:0] rem_d  [DW][LANES];
  logic [DW-1:0] dq_d   [DW][LANES];
  logic [VW-1:0] den_q  [DW];
  logic [VW-1:0] rem_q  [DW][LANES];
  logic [DW-1:0] dq_q   [DW][LANES];
  logic [VW:0]   trial  [DW][LANES];
  logic          take   [DW][LANES];

  always_comb begin
    den_in[0] = den_i;
    for (int l = 0; l < LANES; l++) begin
      rem_in[0][l] = '0;
      dq_in[0][l]  = num_i[l];
    end
    for (int s = 1; s < DW; s++) begin
      den_in[s] = den_q[s-1];
      for (int l = 0; l < LANES; l++) begin
        rem_in[s][l] = rem_q[s-1][l];
        dq_in[s][l]  = dq_q[s-1][l];
      end
    end
    for (int s = 0; s < DW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[s][l] = {rem_in[s][l], dq_in[s][l][DW-1]};
        take[s][l]  = trial[s][l] >= {1'b0, den_in[s]};
        rem_d[s][l] = take[s][l] ? VW'(trial[s][l] - {1'b0, den_in[s]})
                                 : trial[s][l][VW-1:0];
        dq_d[s][l]  = {dq_in[s][l][DW-2:0], take[s][l]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DW; s++) begin
      den_q[s] <= den_in[s];
      for (int l = 0; l < LANES; l++) begin
        rem_q[s][l] <= rem_d[s][l];
        dq_q[s][l]  <= dq_d[s][l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) quo_o[l] = dq_q[DW-1][l];
  end

endmodule

`default_nettype wire

/* src/ilg_front.sv */
// front end: box extents, areas, union and pixel classification
// depends on ilg_pkg
`timescale 1ns / 1ps
`default_nettype none

module ilg_front #(
  parameter int DIST_FRAC_BITS = ilg_pkg::DIST_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic signed [ilg_pkg::DIST_W-1:0] pred_i [4],
  input  logic signed [ilg_pkg::DIST_W-1:0] true_i [4],
  input  logic [ilg_pkg::MINI_W-1:0]        min_inter_i,
  output logic                              push_o,
  output ilg_pkg::item_t                    item_o
);

  localparam int EW = ilg_pkg::EXT_W;
  localparam int AW = ilg_pkg::AREA_W;
  localparam int UW = ilg_pkg::UNION_W;
  localparam logic signed [EW-1:0] ONE = EW'(1 << DIST_FRAC_BITS);

  logic signed [EW-1:0] h_d, w_d, hi_d, wi_d, hg_d, wg_d;
  logic [3:0]           lt_d, gt_d;
  logic                 ign_d;

  logic                 valid1_q;
  logic signed [EW-1:0] h1_q, w1_q, hi1_q, wi1_q, hg1_q, wg1_q;
  logic [3:0]           lt1_q, gt1_q;
  logic                 ign1_q;

  logic                 valid2_q;
  logic signed [AW-1:0] a_d, ag_d, i_d;
  logic signed [AW-1:0] a2_q, ag2_q, i2_q;
  logic signed [EW-1:0] h2_q, w2_q, hi2_q, wi2_q;
  logic [3:0]           lt2_q, gt2_q;
  logic                 ign2_q;

  logic                 valid3_q;
  ilg_pkg::item_t       item_d, item_q;
  logic                 small_d;

  // order of the four sides: top, bottom, left, right
  always_comb begin
    h_d  = EW'(pred_i[1]) + EW'(pred_i[0]) + ONE;
    w_d  = EW'(pred_i[3]) + EW'(pred_i[2]) + ONE;
    hg_d = EW'(true_i[1]) + EW'(true_i[0]) + ONE;
    wg_d = EW'(true_i[3]) + EW'(true_i[2]) + ONE;
    hi_d = EW'((pred_i[1] < true_i[1]) ? pred_i[1] : true_i[1])
         + EW'((pred_i[0] < true_i[0]) ? pred_i[0] : true_i[0]) + ONE;
    wi_d = EW'((pred_i[3] < true_i[3]) ? pred_i[3] : true_i[3])
         + EW'((pred_i[2] < true_i[2]) ? pred_i[2] : true_i[2]) + ONE;
    ign_d = (EW'(true_i[0]) + EW'(true_i[1])) == -ONE;
    for (int k = 0; k < 4; k++) begin
      lt_d[k] = pred_i[k] < true_i[k];
      gt_d[k] = pred_i[k] > true_i[k];
    end
  end

  assign a_d  = AW'(h1_q) * AW'(w1_q);
  assign ag_d = AW'(hg1_q) * AW'(wg1_q);
  assign i_d  = AW'(hi1_q) * AW'(wi1_q);

  assign small_d = i2_q < AW'($signed({1'b0, min_inter_i}));

  always_comb begin
    item_d.uni_area = UW'(a2_q) + UW'(ag2_q) - UW'(i2_q);
    item_d.inter    = i2_q;
    item_d.ext_w    = w2_q;
    item_d.ext_h    = h2_q;
    item_d.ext_wi   = wi2_q;
    item_d.ext_hi   = hi2_q;
    item_d.lt       = lt2_q;
    item_d.gt       = gt2_q;
    item_d.mode     = ign2_q  ? ilg_pkg::MODE_IGNORE :
                      small_d ? ilg_pkg::MODE_L1 : ilg_pkg::MODE_IOU;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= accept_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q   <= h_d;
    w1_q   <= w_d;
    hi1_q  <= hi_d;
    wi1_q  <= wi_d;
    hg1_q  <= hg_d;
    wg1_q  <= wg_d;
    lt1_q  <= lt_d;
    gt1_q  <= gt_d;
    ign1_q <= ign_d;
    a2_q   <= a_d;
    ag2_q  <= ag_d;
    i2_q   <= i_d;
    h2_q   <= h1_q;
    w2_q   <= w1_q;
    hi2_q  <= hi1_q;
    wi2_q  <= wi1_q;
    lt2_q  <= lt1_q;
    gt2_q  <= gt1_q;
    ign2_q <= ign1_q;
    item_q <= item_d;
  end

  assign push_o = valid3_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

/* src/ilg_queue.sv */
// short fifo between front and back, drained whenever it holds a beat
// depends on ilg_pkg
`timescale 1ns / 1ps
`default_nettype none

module ilg_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ilg_pkg::item_t item_i,
  output logic           pop_o,
  output ilg_pkg::item_t item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ilg_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           pop;

  assign pop = cnt_q != '0;

  always_comb begin
    wr_d  = push_i ? ((wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign pop_o  = pop;
  assign item_o = mem_q[rd_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != CW'(DEPTH))
    else $error("queue written while full");

endmodule

`default_nettype wire

/* src/ilg_back.sv */
// back end: six quotients, gradient factors, weight scaling and saturation
// depends on ilg_pkg and ilg_div
`timescale 1ns / 1ps
`default_nettype none

module ilg_back #(
  parameter int DIST_FRAC_BITS = ilg_pkg::DIST_FRAC_BITS,
  parameter int GRAD_FRAC_BITS = ilg_pkg::GRAD_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  ilg_pkg::item_t                      item_i,
  input  logic signed [ilg_pkg::WEIGHT_W-1:0] loss_weight_i,
  output logic                                valid_o,
  output logic signed [ilg_pkg::GRAD_W-1:0]   grad_o [4],
  output logic [ilg_pkg::MODE_W-1:0]          mode_o
);

  localparam int EW    = ilg_pkg::EXT_W;
  localparam int UW    = ilg_pkg::UNION_W;
  localparam int AW    = ilg_pkg::AREA_W;
  localparam int GW    = ilg_pkg::GRAD_W;
  localparam int LW    = ilg_pkg::WEIGHT_W;
  localparam int QSH   = DIST_FRAC_BITS + ilg_pkg::FACT_FRAC;
  localparam int DIV_W = EW + QSH;
  localparam int Q_W   = 63;
  localparam int F_W   = 64;
  localparam int UF_W  = 62;
  localparam int PH_W  = (UF_W - 32) + LW;
  localparam int PR_W  = PH_W + 32;
  localparam int SH    = ilg_pkg::FACT_FRAC + ilg_pkg::WEIGHT_FRAC - GRAD_FRAC_BITS;

  typedef struct packed {
    logic [3:0]                 num_neg;
    logic [3:0]                 num_zero;
    logic                       u_neg;
    logic                       u_zero;
    logic                       i_neg;
    logic                       i_zero;
    logic [3:0]                 lt;
    logic [3:0]                 gt;
    logic [ilg_pkg::MODE_W-1:0] mode;
  } side_t;

  function automatic logic signed [Q_W-1:0] fix_quot(input logic [DIV_W-1:0] mag,
      input logic num_neg, input logic num_zero, input logic den_neg, input logic den_zero);
    logic signed [Q_W-1:0] lim;
    logic signed [Q_W-1:0] val;
    lim     = '0;
    lim[60] = 1'b1;
    val     = Q_W'(mag);
    if (den_zero) begin
      fix_quot = num_zero ? '0 : (num_neg ? -lim : lim);
    end else begin
      fix_quot = (num_neg ^ den_neg) ? -val : val;
    end
  endfunction

  // divider inputs, lanes w, h, wi, hi
  logic signed [EW-1:0] num_s [4];
  logic [EW-1:0]        num_m [4];
  logic [DIV_W-1:0]     div_u_num [4];
  logic [DIV_W-1:0]     div_i_num [2];
  logic [UW-1:0]        den_u, den_i;
  logic [DIV_W-1:0]     quo_u [4];
  logic [DIV_W-1:0]     quo_i [2];
  side_t                side_d;
  side_t                side_q [DIV_W];
  logic [DIV_W-1:0]     vline_q;

  always_comb begin
    num_s[0] = item_i.ext_w;
    num_s[1] = item_i.ext_h;
    num_s[2] = item_i.ext_wi;
    num_s[3] = item_i.ext_hi;
    for (int k = 0; k < 4; k++) begin
      num_m[k]          = num_s[k][EW-1] ? EW'(-num_s[k]) : EW'(num_s[k]);
      div_u_num[k]      = DIV_W'(num_m[k]) << QSH;
      side_d.num_neg[k] = num_s[k][EW-1];
      side_d.num_zero[k] = num_s[k] == '0;
    end
    div_i_num[0] = div_u_num[2];
    div_i_num[1] = div_u_num[3];
    den_u = item_i.uni_area[UW-1] ? UW'(-item_i.uni_area) : UW'(item_i.uni_area);
    den_i = UW'(item_i.inter[AW-1] ? AW'(-item_i.inter) : AW'(item_i.inter));
    side_d.u_neg  = item_i.uni_area[UW-1];
    side_d.u_zero = item_i.uni_area == '0;
    side_d.i_neg  = item_i.inter[AW-1];
    side_d.i_zero = item_i.inter == '0;
    side_d.lt     = item_i.lt;
    side_d.gt     = item_i.gt;
    side_d.mode   = item_i.mode;
  end

  ilg_div #(.DW(DIV_W), .VW(UW), .LANES(4)) u_div_union (
    .clk_i (clk_i),
    .num_i (div_u_num),
    .den_i (den_u),
    .quo_o (quo_u)
  );

  ilg_div #(.DW(DIV_W), .VW(UW), .LANES(2)) u_div_inter (
    .clk_i (clk_i),
    .num_i (div_i_num),
    .den_i (den_i),
    .quo_o (quo_i)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vline_q <= '0;
    end else begin
      vline_q <= {vline_q[DIV_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int s = 1; s < DIV_W; s++) side_q[s] <= side_q[s-1];
  end

  // factor stage
  side_t                sd;
  logic signed [Q_W-1:0] qu [4];
  logic signed [Q_W-1:0] qi [2];
  logic signed [F_W-1:0] c_w, c_h, ext, corr;
  logic signed [F_W-1:0] f_d [4];
  logic signed [F_W-1:0] f_q [4];
  logic signed [F_W-1:0] unit;
  logic [ilg_pkg::MODE_W-1:0] modec_q;
  logic                  validc_q;

  always_comb begin
    sd   = side_q[DIV_W-1];
    unit = F_W'(1) <<< ilg_pkg::FACT_FRAC;
    for (int k = 0; k < 4; k++) begin
      qu[k] = fix_quot(quo_u[k], sd.num_neg[k], sd.num_zero[k], sd.u_neg, sd.u_zero);
    end
    for (int k = 0; k < 2; k++) begin
      qi[k] = fix_quot(quo_i[k], sd.num_neg[k+2], sd.num_zero[k+2], sd.i_neg, sd.i_zero);
    end
    c_w  = F_W'(qu[2]) + F_W'(qi[0]);
    c_h  = F_W'(qu[3]) + F_W'(qi[1]);
    ext  = '0;
    corr = '0;
    for (int k = 0; k < 4; k++) begin
      ext  = (k < 2) ? F_W'(qu[0]) : F_W'(qu[1]);
      corr = (k < 2) ? c_w : c_h;
      case (sd.mode)
        ilg_pkg::MODE_IOU: f_d[k] = ext - (sd.lt[k] ? corr : '0);
        ilg_pkg::MODE_L1:  f_d[k] = sd.gt[k] ? unit : (sd.lt[k] ? -unit : '0);
        default:           f_d[k] = '0;
      endcase
    end
  end

  // partial products stage
  logic [UF_W-1:0] uf [4];
  logic [LW-1:0]   ul;
  logic [PH_W-1:0] ph_q [4];
  logic [63:0]     pl_q [4];
  logic [3:0]      neg_q;
  logic [ilg_pkg::MODE_W-1:0] modem_q;
  logic            validm_q;

  always_comb begin
    ul = loss_weight_i[LW-1] ? LW'(-loss_weight_i) : LW'(loss_weight_i);
    for (int k = 0; k < 4; k++) begin
      uf[k] = f_q[k][F_W-1] ? UF_W'(-f_q[k]) : UF_W'(f_q[k]);
    end
  end

  // sum, shift and saturate
  logic [PR_W-1:0]     prod [4];
  logic [PR_W-1:0]     pmag [4];
  logic signed [GW-1:0] g_d [4];
  logic signed [GW-1:0] g_q [4];
  logic [ilg_pkg::MODE_W-1:0] mode_q;
  logic                valid_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k] = {ph_q[k], 32'b0} + PR_W'(pl_q[k]);
      pmag[k] = prod[k] >> SH;
      if (neg_q[k]) begin
        g_d[k] = (pmag[k] > PR_W'(33'h1_0000_0000 >> 1)) ? {1'b1, {(GW-1){1'b0}}}
                                                         : GW'(-pmag[k][GW-1:0]);
      end else begin
        g_d[k] = (pmag[k] > PR_W'({1'b0, {(GW-1){1'b1}}})) ? {1'b0, {(GW-1){1'b1}}}
                                                           : GW'(pmag[k][GW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      validc_q <= 1'b0;
      validm_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      validc_q <= vline_q[DIV_W-1];
      validm_q <= validc_q;
      valid_q  <= validm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    modec_q <= sd.mode;
    modem_q <= modec_q;
    mode_q  <= modem_q;
    for (int k = 0; k < 4; k++) begin
      f_q[k]   <= f_d[k];
      ph_q[k]  <= PH_W'(uf[k][UF_W-1:32] * ul);
      pl_q[k]  <= 64'(uf[k][31:0] * ul);
      neg_q[k] <= f_q[k][F_W-1] ^ loss_weight_i[LW-1];
      g_q[k]   <= g_d[k];
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  always_comb begin
    for (int k = 0; k < 4; k++) grad_o[k] = g_q[k];
  end

  a_ignore_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && mode_q == ilg_pkg::MODE_IGNORE |->
      g_q[0] == '0 && g_q[1] == '0 && g_q[2] == '0 && g_q[3] == '0)
    else $error("ignored pixel with nonzero gradient");

  a_valid_traced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(vline_q[DIV_W-1], 3))
    else $error("result beat without a divider beat");

endmodule

`default_nettype wire

/* src/iou_loss_gradient.sv */
// top level of the iou loss gradient block: config registers, front, queue, back
// depends on ilg_pkg, ilg_front, ilg_queue, ilg_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel on every cycle that start_i is high (busy_o stays low) and
// returns one result per pixel, in order, each shown for a single cycle with
// done_o high; the receiver cannot stall it. A pixel passes three front
// stages, the queue, one stage per quotient bit of the pipelined restoring
// dividers (18 + DIST_FRAC_BITS + 24 bits) and three stages of factor,
// multiply and saturation.
// Write the registers only while no pixel is in flight.
module iou_loss_gradient #(
  parameter int DIST_FRAC_BITS = ilg_pkg::DIST_FRAC_BITS,
  parameter int GRAD_FRAC_BITS = ilg_pkg::GRAD_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [ilg_pkg::WEIGHT_W-1:0]        cfg_wdata_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [ilg_pkg::DIST_W-1:0]   pred_top_i,
  input  logic signed [ilg_pkg::DIST_W-1:0]   pred_bottom_i,
  input  logic signed [ilg_pkg::DIST_W-1:0]   pred_left_i,
  input  logic signed [ilg_pkg::DIST_W-1:0]   pred_right_i,
  input  logic signed [ilg_pkg::DIST_W-1:0]   true_top_i,
  input  logic signed [ilg_pkg::DIST_W-1:0]   true_bottom_i,
  input  logic signed [ilg_pkg::DIST_W-1:0]   true_left_i,
  input  logic signed [ilg_pkg::DIST_W-1:0]   true_right_i,
  output logic                                done_o,
  output logic signed [ilg_pkg::GRAD_W-1:0]   grad_top_o,
  output logic signed [ilg_pkg::GRAD_W-1:0]   grad_bottom_o,
  output logic signed [ilg_pkg::GRAD_W-1:0]   grad_left_o,
  output logic signed [ilg_pkg::GRAD_W-1:0]   grad_right_o,
  output logic [ilg_pkg::MODE_W-1:0]          pixel_mode_o
);

  logic signed [ilg_pkg::WEIGHT_W-1:0] loss_weight_q;
  logic [ilg_pkg::MINI_W-1:0]          min_inter_q;

  logic signed [ilg_pkg::DIST_W-1:0] pred [4];
  logic signed [ilg_pkg::DIST_W-1:0] tru  [4];
  logic signed [ilg_pkg::GRAD_W-1:0] grad [4];
  logic                              push, pop, accept;
  ilg_pkg::item_t                    front_item, queue_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_weight_q <= 32'sh0100_0000;
      min_inter_q   <= 20'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ilg_pkg::REG_LOSS_WEIGHT: loss_weight_q <= cfg_wdata_i;
        ilg_pkg::REG_MIN_INTER:   min_inter_q   <= cfg_wdata_i[ilg_pkg::MINI_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign pred[0] = pred_top_i;
  assign pred[1] = pred_bottom_i;
  assign pred[2] = pred_left_i;
  assign pred[3] = pred_right_i;
  assign tru[0]  = true_top_i;
  assign tru[1]  = true_bottom_i;
  assign tru[2]  = true_left_i;
  assign tru[3]  = true_right_i;

  ilg_front #(.DIST_FRAC_BITS(DIST_FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pred_i      (pred),
    .true_i      (tru),
    .min_inter_i (min_inter_q),
    .push_o      (push),
    .item_o      (front_item)
  );

  ilg_queue #(.DEPTH(2)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_o  (pop),
    .item_o (queue_item)
  );

  ilg_back #(
    .DIST_FRAC_BITS (DIST_FRAC_BITS),
    .GRAD_FRAC_BITS (GRAD_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (pop),
    .item_i        (queue_item),
    .loss_weight_i (loss_weight_q),
    .valid_o       (done_o),
    .grad_o        (grad),
    .mode_o        (pixel_mode_o)
  );

  assign grad_top_o    = grad[0];
  assign grad_bottom_o = grad[1];
  assign grad_left_o   = grad[2];
  assign grad_right_o  = grad[3];

endmodule

`default_nettype wire

/* test/iou_loss_gradient_tb.sv */
// self-checking testbench for the iou loss gradient block: directed pixels,
// register sweeps and random pixels checked against an in-bench gradient predictor
// depends on ilg_pkg and iou_loss_gradient
`timescale 1ns / 1ps

module iou_loss_gradient_tb;

  localparam int LATENCY    = ilg_pkg::DIST_FRAC_BITS + 49;
  localparam int IDLE_LIMIT = 4000;
  localparam int PROD_SHIFT = ilg_pkg::FACT_FRAC + ilg_pkg::WEIGHT_FRAC
                              - ilg_pkg::GRAD_FRAC_BITS;

  typedef struct {
    logic signed [ilg_pkg::DIST_W-1:0] pt, pb, pl, pr, tt, tb, tl, tr;
  } pixel_t;

  typedef struct {
    logic [ilg_pkg::GRAD_W-1:0] grad [4];
    logic [ilg_pkg::MODE_W-1:0] mode;
  } grad_set_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = ilg_pkg::REG_LOSS_WEIGHT;
  logic [ilg_pkg::WEIGHT_W-1:0] cfg_wdata_i = '0;
  logic start_i = 1'b0;
  logic busy_o, done_o;
  logic signed [ilg_pkg::DIST_W-1:0] pred_top_i = '0, pred_bottom_i = '0;
  logic signed [ilg_pkg::DIST_W-1:0] pred_left_i = '0, pred_right_i = '0;
  logic signed [ilg_pkg::DIST_W-1:0] true_top_i = '0, true_bottom_i = '0;
  logic signed [ilg_pkg::DIST_W-1:0] true_left_i = '0, true_right_i = '0;
  logic signed [ilg_pkg::GRAD_W-1:0] grad_top_o, grad_bottom_o, grad_left_o, grad_right_o;
  logic [ilg_pkg::MODE_W-1:0] pixel_mode_o;

  iou_loss_gradient uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i, .busy_o,
    .pred_top_i, .pred_bottom_i, .pred_left_i, .pred_right_i,
    .true_top_i, .true_bottom_i, .true_left_i, .true_right_i,
    .done_o, .grad_top_o, .grad_bottom_o, .grad_left_o, .grad_right_o, .pixel_mode_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint weight_q = longint'(1) << ilg_pkg::WEIGHT_FRAC;
  longint min_inter_q = 1;
  grad_set_t pending_grads[$];
  int mismatches = 0;
  bit beat_seen = 1'b0;
  int idle_cycles = 0;

  function automatic longint quotient(longint num, longint den);
    longint n;
    n = num * (longint'(1) << (ilg_pkg::DIST_FRAC_BITS + ilg_pkg::FACT_FRAC));
    if (den == 0) return n > 0 ? (longint'(1) << 60) : (n < 0 ? -(longint'(1) << 60) : 0);
    return n / den;
  endfunction

  function automatic logic [ilg_pkg::GRAD_W-1:0] scale_grad(longint f);
    logic neg;
    logic [63:0] uf, ul;
    logic [127:0] p;
    neg = (f < 0) != (weight_q < 0);
    uf = f < 0 ? -f : f;
    ul = weight_q < 0 ? -weight_q : weight_q;
    p = ({64'd0, uf} * {64'd0, ul}) >> PROD_SHIFT;
    if (neg) begin
      if (p > (128'd1 << 31)) p = 128'd1 << 31;
      return -p[31:0];
    end
    if (p > 128'h7FFF_FFFF) p = 128'h7FFF_FFFF;
    return p[31:0];
  endfunction

  function automatic longint sgn_diff(longint a, longint b);
    return longint'(a > b) - longint'(a < b);
  endfunction

  function automatic longint min_l(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic grad_set_t predict_grads(pixel_t px);
    grad_set_t r;
    longint one, t, b, l, rr, tg, bg, lg, rg, h, w, hi, wi, inter, uni, qw, qh, cw, ch;
    longint f [4];
    one = longint'(1) << ilg_pkg::DIST_FRAC_BITS;
    t = px.pt; b = px.pb; l = px.pl; rr = px.pr;
    tg = px.tt; bg = px.tb; lg = px.tl; rg = px.tr;
    if (tg + bg == -one) begin
      foreach (r.grad[k]) r.grad[k] = '0;
      r.mode = ilg_pkg::MODE_IGNORE;
      return r;
    end
    h = b + t + one;
    w = rr + l + one;
    hi = min_l(b, bg) + min_l(t, tg) + one;
    wi = min_l(rr, rg) + min_l(l, lg) + one;
    inter = hi * wi;
    if (inter < min_inter_q) begin
      f[0] = sgn_diff(t, tg) << ilg_pkg::FACT_FRAC;
      f[1] = sgn_diff(b, bg) << ilg_pkg::FACT_FRAC;
      f[2] = sgn_diff(l, lg) << ilg_pkg::FACT_FRAC;
      f[3] = sgn_diff(rr, rg) << ilg_pkg::FACT_FRAC;
      r.mode = ilg_pkg::MODE_L1;
    end else begin
      uni = h * w + (bg + tg + one) * (rg + lg + one) - inter;
      qw = quotient(w, uni);
      qh = quotient(h, uni);
      cw = quotient(wi, uni) + quotient(wi, inter);
      ch = quotient(hi, uni) + quotient(hi, inter);
      f[0] = qw - (t < tg ? cw : 0);
      f[1] = qw - (b < bg ? cw : 0);
      f[2] = qh - (l < lg ? ch : 0);
      f[3] = qh - (rr < rg ? ch : 0);
      r.mode = ilg_pkg::MODE_IOU;
    end
    foreach (f[k]) r.grad[k] = scale_grad(f[k]);
    return r;
  endfunction

  // one beat per call; start stays high into the next call when no gap is drawn
  task automatic send_pixel(pixel_t px);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pred_top_i <= px.pt; pred_bottom_i <= px.pb;
    pred_left_i <= px.pl; pred_right_i <= px.pr;
    true_top_i <= px.tt; true_bottom_i <= px.tb;
    true_left_i <= px.tl; true_right_i <= px.tr;
    start_i <= 1'b1;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_grads.push_back(predict_grads(px));
    beat_seen = 1'b1;
  endtask

  task automatic write_reg(logic idx, logic [ilg_pkg::WEIGHT_W-1:0] value);
    if (start_i) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    wait (pending_grads.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ilg_pkg::REG_LOSS_WEIGHT) weight_q = longint'(signed'(value));
    else min_inter_q = value[ilg_pkg::MINI_W-1:0];
  endtask

  function automatic pixel_t make_pixel(int dp0, int dp1, int dp2, int dp3,
                                        int dt0, int dt1, int dt2, int dt3);
    pixel_t px;
    px.pt = dp0; px.pb = dp1; px.pl = dp2; px.pr = dp3;
    px.tt = dt0; px.tb = dt1; px.tl = dt2; px.tr = dt3;
    return px;
  endfunction

  function automatic logic [ilg_pkg::DIST_W-1:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'hFFC0;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // plausible boxes: non-negative true distances, often overlapping
      px.tt = $urandom_range(0, 3000); px.tb = $urandom_range(0, 3000);
      px.tl = $urandom_range(0, 3000); px.tr = $urandom_range(0, 3000);
      px.pt = $urandom_range(0, 1) ? px.tt + $signed($urandom_range(0, 800)) - 400
                                    : $urandom_range(0, 3000);
      px.pb = px.tb + $signed($urandom_range(0, 800)) - 400;
      px.pl = $urandom_range(0, 1) ? px.tl : $urandom_range(0, 3000);
      px.pr = px.tr + $signed($urandom_range(0, 200)) - 100;
    end else if (kind == 6) begin
      px = make_pixel($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
    end else if (kind == 7) begin
      px = make_pixel($urandom, $urandom, $urandom, $urandom,
                      0, 0, $urandom, $urandom);
      px.tb = -(1 << ilg_pkg::DIST_FRAC_BITS) - px.tt;
    end else begin
      px = make_pixel(corner_value(), corner_value(), corner_value(), corner_value(),
                      corner_value(), corner_value(), corner_value(), corner_value());
    end
    return px;
  endfunction

  task automatic test_directed();
    send_pixel(make_pixel(640, 640, 640, 640, 640, 640, 640, 640));
    send_pixel(make_pixel(600, 700, 500, 800, 640, 640, 640, 640));
    send_pixel(make_pixel(100, 200, 300, 400, -32768, 32767, 5, 6));
    send_pixel(make_pixel(32767, -32768, 0, -1, 0, -64, 1, 1));
    send_pixel(make_pixel(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pixel(make_pixel(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pixel(make_pixel(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768));
    // no overlap, yet a positive intersection: iou path with each sign
    send_pixel(make_pixel(-200, 10, 10, -200, 10, -200, -200, 10));
    send_pixel(make_pixel(5, 5, 5, 5, 5, 5, 5, 5));
    send_pixel(make_pixel(0, -64, 0, -64, 0, -64, 0, -64));
  endtask

  task automatic test_zero_divisors();
    write_reg(ilg_pkg::REG_MIN_INTER, 0);
    // zero union and zero intersection
    send_pixel(make_pixel(-64, 0, -64, 0, 0, 0, -64, 0));
    send_pixel(make_pixel(-64, 0, 100, 100, 0, 0, 100, 100));
    send_pixel(make_pixel(-300, 10, 50, 50, 100, 100, 50, 50));
    write_reg(ilg_pkg::REG_LOSS_WEIGHT, 0);
    send_pixel(make_pixel(-64, 0, -64, 0, 0, 0, -64, 0));
    send_pixel(make_pixel(600, 700, 500, 800, 640, 640, 640, 640));
  endtask

  task automatic test_random_sweep();
    logic [ilg_pkg::WEIGHT_W-1:0] weights [6];
    logic [ilg_pkg::WEIGHT_W-1:0] mins [6];
    weights = '{32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFF00_0000,
                $urandom, 32'h0000_0001};
    mins = '{1, 20'hFFFFF, 0, $urandom_range(0, 20'hFFFFF), 4096, $urandom_range(1, 99999)};
    for (int s = 0; s < 6; s++) begin
      write_reg(ilg_pkg::REG_LOSS_WEIGHT, weights[s]);
      write_reg(ilg_pkg::REG_MIN_INTER, mins[s]);
      repeat (240) send_pixel(random_pixel());
    end
  endtask

  always @(posedge clk_i) begin
    grad_set_t want;
    logic [ilg_pkg::GRAD_W-1:0] got [4];
    bit bad;
    if (done_o) begin
      beat_seen = 1'b1;
      got = '{grad_top_o, grad_bottom_o, grad_left_o, grad_right_o};
      if (pending_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = pending_grads.pop_front();
        bad = pixel_mode_o != want.mode;
        for (int k = 0; k < 4; k++) if (got[k] != want.grad[k]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp %h %h %h %h mode %0d, got %h %h %h %h mode %0d",
                     $realtime, want.grad[0], want.grad[1], want.grad[2], want.grad[3],
                     want.mode, got[0], got[1], got[2], got[3], pixel_mode_o);
        end
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk_i) begin
    if (beat_seen || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    beat_seen = 1'b0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_divisors();
    test_random_sweep();
    start_i <= 1'b0;
    wait (pending_grads.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
